// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the rectangle fill block.
// Needs nothing else; each user passes its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== sv/abrf_pkg.sv =====
// Shared types, constants and blend arithmetic for the rectangle fill block.
// No dependencies; the front end, queue, back end and top refer to it by scoped names.
package abrf_pkg;

    localparam int COORD_W   = 13;   // holds any clipped corner up to 4096
    localparam int CNT_W     = 13;   // pixel count, wraps
    localparam int PIX_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] ACTIVE_SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_READ  = 2'd1,
        OP_STORE = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // What the back end has to do with a queued item.
    typedef enum logic [1:0] {
        K_NONE  = 2'd0,   // answer with zeros, touch nothing
        K_FILL  = 2'd1,
        K_READ  = 2'd2,
        K_STORE = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_WIDTH  = 1'b0,
        REG_ACTIVE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Classified command: for a fill, x0/y0 inclusive and x1/y1 exclusive
    // clipped corners; for read and store, x0/y0 is the pixel address.
    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    // a*s + (255-a)*d, at most 65025.
    function automatic logic [15:0] blend_mul(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] s,
                                              input logic [CHAN_W-1:0] d);
        logic [CHAN_W-1:0] na;
        na = 8'hFF - a;
        blend_mul = 16'(a) * 16'(s) + 16'(na) * 16'(d);
    endfunction

    // Exact floor(v/255) for v below 65280.
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] v);
        logic [15:0] t;
        t = v + {8'd0, v[15:8]} + 16'd1;
        div255 = t[15:8];
    endfunction

endpackage

// ===== sv/abrf_if.sv =====
// Handshake channels of the rectangle fill block: request and response.
// Standalone; payload widths follow the fixed field widths.
interface abrf_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic [31:0]        color;
    logic [5:0]         addr_x;
    logic [5:0]         addr_y;

    modport source (output valid, op, min_x, min_y, max_x, max_y, color, addr_x, addr_y,
                     input ready);
    modport sink (input valid, op, min_x, min_y, max_x, max_y, color, addr_x, addr_y,
                   output ready);
endinterface

interface abrf_rsp_if;
    logic        valid;
    logic        ready;
    logic [23:0] read_rgb;
    logic [12:0] pixels_written;

    modport source (output valid, read_rgb, pixels_written, input ready);
    modport sink (input valid, read_rgb, pixels_written, output ready);
endinterface

// ===== sv/abrf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone.
module abrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/abrf_front.sv =====
// Front end: active-size registers, request intake, clipping and classification.
// Depends on abrf_pkg and abrf_if.
module abrf_front #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [abrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abrf_pkg::CFG_W-1:0]     cfg_data,
    abrf_req_if.sink                       req,
    input  logic                           clear_busy,
    input  logic                           q_full,
    output logic                           push,
    output abrf_pkg::cmd_t                 push_cmd
);

    localparam logic signed [16:0] LIM_X_MAX = 17'(MAX_WIDTH);
    localparam logic signed [16:0] LIM_Y_MAX = 17'(MAX_HEIGHT);

    logic [abrf_pkg::CFG_W-1:0] act_w_reg, act_w_next;
    logic [abrf_pkg::CFG_W-1:0] act_h_reg, act_h_next;

    logic signed [16:0] act_w_s, act_h_s, lim_x, lim_y;
    logic signed [16:0] min_x_s, min_y_s, max_x_s, max_y_s;
    logic signed [16:0] x0_s, y0_s, x1_s, y1_s;
    logic               empty, addr_in_store;

    always_comb
    begin
        act_w_next = act_w_reg;
        act_h_next = act_h_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                abrf_pkg::REG_ACTIVE_WIDTH:  act_w_next = cfg_data;
                abrf_pkg::REG_ACTIVE_HEIGHT: act_h_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_w_reg <= abrf_pkg::ACTIVE_SIZE_RESET;
            act_h_reg <= abrf_pkg::ACTIVE_SIZE_RESET;
        end
        else
        begin
            act_w_reg <= act_w_next;
            act_h_reg <= act_h_next;
        end
    end

    // Clip limits saturate at the store size.
    assign act_w_s = signed'({10'd0, act_w_reg});
    assign act_h_s = signed'({10'd0, act_h_reg});
    assign lim_x   = (act_w_s > LIM_X_MAX) ? LIM_X_MAX : act_w_s;
    assign lim_y   = (act_h_s > LIM_Y_MAX) ? LIM_Y_MAX : act_h_s;

    assign min_x_s = {req.min_x[15], req.min_x};
    assign min_y_s = {req.min_y[15], req.min_y};
    assign max_x_s = {req.max_x[15], req.max_x};
    assign max_y_s = {req.max_y[15], req.max_y};

    assign x0_s = (min_x_s < 17'sd0) ? 17'sd0 : min_x_s;
    assign y0_s = (min_y_s < 17'sd0) ? 17'sd0 : min_y_s;
    assign x1_s = (max_x_s > lim_x) ? lim_x : max_x_s;
    assign y1_s = (max_y_s > lim_y) ? lim_y : max_y_s;

    assign empty  = (x0_s >= x1_s) || (y0_s >= y1_s);
    assign addr_in_store =
        (abrf_pkg::COORD_W'(req.addr_x) < abrf_pkg::COORD_W'(MAX_WIDTH)) &&
        (abrf_pkg::COORD_W'(req.addr_y) < abrf_pkg::COORD_W'(MAX_HEIGHT));

    always_comb
    begin
        push_cmd       = '0;
        push_cmd.kind  = abrf_pkg::K_NONE;
        push_cmd.color = req.color;
        case (abrf_pkg::op_t'(req.op))
            abrf_pkg::OP_FILL:
            begin
                // Corners are only meaningful when the rectangle is not empty.
                if (!empty)
                begin
                    push_cmd.kind = abrf_pkg::K_FILL;
                    push_cmd.x0   = x0_s[abrf_pkg::COORD_W-1:0];
                    push_cmd.y0   = y0_s[abrf_pkg::COORD_W-1:0];
                    push_cmd.x1   = x1_s[abrf_pkg::COORD_W-1:0];
                    push_cmd.y1   = y1_s[abrf_pkg::COORD_W-1:0];
                end
            end
            abrf_pkg::OP_READ, abrf_pkg::OP_STORE:
            begin
                if (addr_in_store)
                begin
                    push_cmd.kind = (abrf_pkg::op_t'(req.op) == abrf_pkg::OP_READ) ?
                                    abrf_pkg::K_READ : abrf_pkg::K_STORE;
                end
                push_cmd.x0 = abrf_pkg::COORD_W'(req.addr_x);
                push_cmd.y0 = abrf_pkg::COORD_W'(req.addr_y);
            end
            default: ;
        endcase
    end

    assign req.ready = !q_full && !clear_busy;
    assign push      = req.valid && req.ready;

endmodule

// ===== sv/abrf_cmd_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on abrf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abrf_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  abrf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           cmd_valid,
    output abrf_pkg::cmd_t cmd
);

    localparam int DEPTH   = 2;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    abrf_pkg::cmd_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !full)
    `ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, pop, cmd_valid)

endmodule

// ===== sv/abrf_back.sv =====
// Back end: clearing pass, fill read-modify-write pipeline, read/store, result register.
// Depends on abrf_pkg, abrf_if, abrf_ram and assert_macros.svh.
`include "assert_macros.svh"

module abrf_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  abrf_pkg::cmd_t cmd,
    output logic           pop,
    output logic           clear_busy,
    abrf_rsp_if.source     rsp
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XCW   = $clog2(MAX_WIDTH + 1);
    localparam int YCW   = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = abrf_pkg::CHAN_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_READ  = 5'b10000
    } state_t;

    function automatic logic [AW-1:0] pix_addr(input logic [abrf_pkg::COORD_W-1:0] px,
                                               input logic [abrf_pkg::COORD_W-1:0] py);
        pix_addr = AW'(32'(py) * MAX_WIDTH + 32'(px));
    endfunction

    state_t state_reg, state_next;
    logic [AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [XCW-1:0] x_reg, x_next, xs_reg, xs_next, xe_reg, xe_next, x_inc;
    logic [YCW-1:0] y_reg, y_next, ye_reg, ye_next, y_inc;
    logic [CW-1:0]  a_reg, a_next;
    logic [abrf_pkg::PIX_W-1:0] src_reg, src_next;
    logic [abrf_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic           s1_v_reg, s2_v_reg;
    logic [AW-1:0]  s1_addr_reg, s2_addr_reg;
    logic [15:0]    p_r_reg, p_g_reg, p_b_reg;

    logic           out_valid_reg, out_valid_next;
    logic [abrf_pkg::PIX_W-1:0] out_rgb_reg, out_rgb_next;
    logic [abrf_pkg::CNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic           out_free, emit;
    logic [abrf_pkg::PIX_W-1:0] emit_rgb;
    logic [abrf_pkg::CNT_W-1:0] emit_cnt;

    logic           rd_en, we;
    logic [AW-1:0]  rd_addr, waddr;
    logic [abrf_pkg::PIX_W-1:0] wdata, rd_data, blended;

    abrf_ram #(
        .WIDTH (abrf_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign out_free   = !out_valid_reg || rsp.ready;
    assign clear_busy = (state_reg == ST_CLEAR);
    assign x_inc      = x_reg + XCW'(1);
    assign y_inc      = y_reg + YCW'(1);

    assign blended = {abrf_pkg::div255(p_r_reg + 16'd127),
                      abrf_pkg::div255(p_g_reg + 16'd127),
                      abrf_pkg::div255(p_b_reg + 16'd127)};

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        xs_next       = xs_reg;
        xe_next       = xe_reg;
        ye_next       = ye_reg;
        a_next        = a_reg;
        src_next      = src_reg;
        cnt_next      = cnt_reg;
        pop           = 1'b0;
        emit          = 1'b0;
        emit_rgb      = '0;
        emit_cnt      = '0;
        rd_en         = 1'b0;
        rd_addr       = pix_addr(abrf_pkg::COORD_W'(x_reg), abrf_pkg::COORD_W'(y_reg));
        we            = 1'b0;
        waddr         = pix_addr(cmd.x0, cmd.y0);
        wdata         = cmd.color[abrf_pkg::PIX_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                we            = 1'b1;
                waddr         = clr_addr_reg;
                wdata         = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    pop = 1'b1;
                    case (cmd.kind)
                        abrf_pkg::K_FILL:
                        begin
                            x_next     = cmd.x0[XCW-1:0];
                            xs_next    = cmd.x0[XCW-1:0];
                            xe_next    = cmd.x1[XCW-1:0];
                            y_next     = cmd.y0[YCW-1:0];
                            ye_next    = cmd.y1[YCW-1:0];
                            a_next     = cmd.color[31:24];
                            src_next   = cmd.color[abrf_pkg::PIX_W-1:0];
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        abrf_pkg::K_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pix_addr(cmd.x0, cmd.y0);
                            state_next = ST_READ;
                        end
                        abrf_pkg::K_STORE:
                        begin
                            we   = 1'b1;
                            emit = 1'b1;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                // One pixel read issued per cycle, raster order.
                rd_en    = 1'b1;
                cnt_next = cnt_reg + abrf_pkg::CNT_W'(1);
                if (x_inc == xe_reg)
                begin
                    x_next = xs_reg;
                    y_next = y_inc;
                    if (y_inc == ye_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    x_next = x_inc;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg && out_free)
                begin
                    emit       = 1'b1;
                    emit_cnt   = cnt_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                emit       = 1'b1;
                emit_rgb   = rd_data;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Write-back of the fill pipeline; only live in FILL and DRAIN.
        if (s2_v_reg)
        begin
            we    = 1'b1;
            waddr = s2_addr_reg;
            wdata = blended;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rgb_next   = out_rgb_reg;
        out_cnt_next   = out_cnt_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_rgb_next   = emit_rgb;
            out_cnt_next   = emit_cnt;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            s1_v_reg      <= (state_reg == ST_FILL);
            s2_v_reg      <= s1_v_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        xs_reg      <= xs_next;
        xe_reg      <= xe_next;
        ye_reg      <= ye_next;
        a_reg       <= a_next;
        src_reg     <= src_next;
        cnt_reg     <= cnt_next;
        s1_addr_reg <= rd_addr;
        s2_addr_reg <= s1_addr_reg;
        p_r_reg     <= abrf_pkg::blend_mul(a_reg, src_reg[23:16], rd_data[23:16]);
        p_g_reg     <= abrf_pkg::blend_mul(a_reg, src_reg[15:8], rd_data[15:8]);
        p_b_reg     <= abrf_pkg::blend_mul(a_reg, src_reg[7:0], rd_data[7:0]);
        out_rgb_reg <= out_rgb_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_rgb       = out_rgb_reg;
    assign rsp.pixels_written = out_cnt_reg;

    `ASSERT_IMP(a_emit_needs_free_slot, clk, rst_n, emit, out_free)
    `ASSERT_IMP(a_rmw_no_overlap, clk, rst_n, rd_en && s2_v_reg, rd_addr != s2_addr_reg)
    `ASSERT_IMP(a_pop_with_empty_pipe, clk, rst_n, pop, !s1_v_reg && !s2_v_reg)
    `ASSERT_NEXT(a_read_answers_next, clk, rst_n, pop && (cmd.kind == abrf_pkg::K_READ),
                 emit)

endmodule

// ===== sv/alpha_blended_rectangle_fill_core.sv =====
// Alpha-blended rectangle fill over an on-chip RGB frame store.
// Channels: req carries one item (op, corners, color, pixel address); rsp
// returns one item for every request (read_rgb, pixels_written). Both use
// valid/ready; an item moves on a rising edge with both high. cfg_we,
// cfg_index and cfg_data write active_width / active_height; the user must
// write them while idle only, which the block does not enforce. After reset
// the store of MAX_WIDTH*MAX_HEIGHT pixels (4096 by default) is swept to
// zero, one pixel per cycle; req.ready stays low during the sweep. A store,
// a no-op or an empty fill is answered from idle through the result
// register; a read first passes the registered RAM read; a fill issues one
// read per pixel, then two blend and write-back stages drain before the
// count is posted. Throughput is one pixel per cycle, set by the single
// read and single write port of the frame store RAM.
// A two-entry queue takes new requests while the back end works or while
// a result waits; a stalled rsp holds its item and stops the back end.
module alpha_blended_rectangle_fill_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [abrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abrf_pkg::CFG_W-1:0]     cfg_data,
    abrf_req_if.sink                       req,
    abrf_rsp_if.source                     rsp
);

    // Front end to queue.
    logic           push;
    abrf_pkg::cmd_t push_cmd;
    logic           q_full;

    // Queue to back end.
    logic           cmd_valid;
    abrf_pkg::cmd_t cmd;
    logic           pop;

    // Back end holds off intake during the clearing sweep.
    logic           clear_busy;

    abrf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    abrf_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    abrf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .pop        (pop),
        .clear_busy (clear_busy),
        .rsp        (rsp)
    );

endmodule
